[src/pal_pkg.sv]
`default_nettype none

package pal_pkg;

  // list geometry
  localparam int unsigned Depth  = 128;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);

  // payload widths
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 8;

  // width for position against count comparisons
  localparam int unsigned CmpW   = (CntW > PosW) ? CntW : PosW;

  // operation codes
  localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [ModeW-1:0] MODE_INSERT = 3'd1;
  localparam logic [ModeW-1:0] MODE_EDIT   = 3'd2;
  localparam logic [ModeW-1:0] MODE_DELETE = 3'd3;
  localparam logic [ModeW-1:0] MODE_READ   = 3'd4;

  // result status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatW-1:0] ST_RANGE = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load_op;
    logic check;
    logic cnt_clear;
    logic cnt_inc;
    logic cnt_dec;
    logic mem_edit;
    logic rd_pos;
    logic idx_init;
    logic shift_en;
    logic ins_final;
    logic out_load;
  } pal_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ok;
    logic is_clear;
    logic is_insert;
    logic is_edit;
    logic is_delete;
    logic is_read;
    logic more;
    logic pend;
    logic out_free;
  } pal_stat_t;

endpackage

`default_nettype wire

[src/pal_if.sv]
`default_nettype none

// request channel
interface pal_in_if;
  logic                              valid;
  logic                              ready;
  logic        [pal_pkg::ModeW-1:0]  mode;
  logic        [pal_pkg::PosW-1:0]   position;
  logic signed [pal_pkg::DataW-1:0]  value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// result channel
interface pal_out_if;
  logic                              valid;
  logic                              ready;
  logic        [pal_pkg::StatW-1:0]  status;
  logic signed [pal_pkg::DataW-1:0]  read_value;
  logic        [pal_pkg::CountW-1:0] count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

`default_nettype wire

[src/pal_ctrl.sv]
`default_nettype none

module pal_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pal_pkg::pal_stat_t stat_i,
  output pal_pkg::pal_cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.check = 1'b1;
        state_d     = S_FINISH;
        if (stat_i.ok) begin
          if (stat_i.is_clear) begin
            cmd_o.cnt_clear = 1'b1;
          end else if (stat_i.is_edit) begin
            cmd_o.mem_edit = 1'b1;
          end else if (stat_i.is_read) begin
            cmd_o.rd_pos = 1'b1;
          end else if (stat_i.is_insert || stat_i.is_delete) begin
            cmd_o.idx_init = 1'b1;
            state_d        = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        // done once no read is left and the last move is written
        if (!stat_i.more && !stat_i.pend) begin
          if (stat_i.is_insert) begin
            cmd_o.ins_final = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/pal_dp.sv]
`default_nettype none

module pal_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic        [pal_pkg::ModeW-1:0]   in_mode_i,
  input  wire logic        [pal_pkg::PosW-1:0]    in_position_i,
  input  wire logic signed [pal_pkg::DataW-1:0]   in_value_i,
  input  wire pal_pkg::pal_cmd_t                  cmd_i,
  output pal_pkg::pal_stat_t                      stat_o,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic             [pal_pkg::StatW-1:0]   out_status_o,
  output logic signed      [pal_pkg::DataW-1:0]   out_read_value_o,
  output logic             [pal_pkg::CountW-1:0]  out_count_o
);

  // operation registers
  logic [pal_pkg::ModeW-1:0] op_mode_q;
  logic [pal_pkg::PosW-1:0]  op_pos_q;
  logic [pal_pkg::DataW-1:0] op_val_q;

  logic [pal_pkg::CntW-1:0]  count_q, count_d;
  logic [pal_pkg::StatW-1:0] status_q, status;

  // shift engine
  logic [pal_pkg::IdxW-1:0]  idx_q, idx_d, src;
  logic [pal_pkg::IdxW-1:0]  wdst_q;
  logic                      pend_q, pend_d;
  logic                      more;

  // element store
  logic [pal_pkg::DataW-1:0] mem [pal_pkg::Depth];
  logic [pal_pkg::DataW-1:0] rd_q;
  logic                      we, re;
  logic [pal_pkg::IdxW-1:0]  waddr, raddr;
  logic [pal_pkg::DataW-1:0] wdata;

  // result register
  logic                      out_valid_q;
  logic [pal_pkg::StatW-1:0] out_status_q;
  logic [pal_pkg::DataW-1:0] out_value_q;
  logic [pal_pkg::CountW-1:0] out_count_q;

  logic is_clear, is_insert, is_edit, is_delete, is_read;
  logic [pal_pkg::CmpW-1:0] pos_c, cnt_c, idx_c;

  assign is_clear  = (op_mode_q == pal_pkg::MODE_CLEAR);
  assign is_insert = (op_mode_q == pal_pkg::MODE_INSERT);
  assign is_edit   = (op_mode_q == pal_pkg::MODE_EDIT);
  assign is_delete = (op_mode_q == pal_pkg::MODE_DELETE);
  assign is_read   = (op_mode_q == pal_pkg::MODE_READ);

  assign pos_c = pal_pkg::CmpW'(op_pos_q);
  assign cnt_c = pal_pkg::CmpW'(count_q);
  assign idx_c = pal_pkg::CmpW'(idx_q);

  // error checks, full or empty before range
  always_comb begin
    status = pal_pkg::ST_OK;
    case (op_mode_q)
      pal_pkg::MODE_INSERT: begin
        if (cnt_c >= pal_pkg::CmpW'(pal_pkg::Depth)) begin
          status = pal_pkg::ST_FULL;
        end else if (pos_c > cnt_c) begin
          status = pal_pkg::ST_RANGE;
        end
      end
      pal_pkg::MODE_EDIT, pal_pkg::MODE_DELETE, pal_pkg::MODE_READ: begin
        if (count_q == '0) begin
          status = pal_pkg::ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = pal_pkg::ST_RANGE;
        end
      end
      default: begin
        status = pal_pkg::ST_OK;
      end
    endcase
  end

  // next move: insert walks down from the end, delete walks up from position
  always_comb begin
    if (is_insert) begin
      more = (idx_c > pos_c);
      src  = idx_q - pal_pkg::IdxW'(1);
    end else begin
      more = ((idx_c + pal_pkg::CmpW'(1)) < cnt_c);
      src  = idx_q + pal_pkg::IdxW'(1);
    end
  end

  always_comb begin
    idx_d  = idx_q;
    pend_d = cmd_i.shift_en && more;
    if (cmd_i.idx_init) begin
      idx_d = is_insert ? pal_pkg::IdxW'(count_q) : pal_pkg::IdxW'(op_pos_q);
    end else if (cmd_i.shift_en && more) begin
      idx_d = src;
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = pal_pkg::IdxW'(op_pos_q);
    wdata = op_val_q;
    if (pend_q) begin
      we    = 1'b1;
      waddr = wdst_q;
      wdata = rd_q;
    end else if (cmd_i.mem_edit || cmd_i.ins_final) begin
      we = 1'b1;
    end
    re    = cmd_i.rd_pos || (cmd_i.shift_en && more);
    raddr = cmd_i.rd_pos ? pal_pkg::IdxW'(op_pos_q) : src;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // count update
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clear) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + pal_pkg::CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - pal_pkg::CntW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      op_mode_q <= in_mode_i;
      op_pos_q  <= in_position_i;
      op_val_q  <= in_value_i;
    end
    if (cmd_i.check) begin
      status_q <= status;
    end
    if (cmd_i.shift_en) begin
      wdst_q <= idx_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_value_q  <= (is_read && status_q == pal_pkg::ST_OK) ? rd_q : '0;
      out_count_q  <= pal_pkg::CountW'(count_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.ok        = (status == pal_pkg::ST_OK);
  assign stat_o.is_clear  = is_clear;
  assign stat_o.is_insert = is_insert;
  assign stat_o.is_edit   = is_edit;
  assign stat_o.is_delete = is_delete;
  assign stat_o.is_read   = is_read;
  assign stat_o.more      = more;
  assign stat_o.pend      = pend_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_read_value_o = out_value_q;
  assign out_count_o      = out_count_q;

endmodule

`default_nettype wire

[src/positional_array_list.sv]
`default_nettype none

// Ordered list of up to 128 signed 32-bit entries with an entry count.
// item_i carries one request (mode, position, value) per transfer; result_o
// returns one result (status, read_value, count) per request, in order.
// Both channels transfer on a rising edge with valid and ready high.
// Modes: clear, insert at position, edit, delete at position, read.
// A failing request (list full, list empty, position out of range)
// changes nothing and reports its status.
// Clear, edit, read, errors and unused modes finish without moving
// entries. Insert and delete move up to 127 entries: the element memory
// moves one entry per cycle, reads running ahead of writes through the
// read register, and the last write settles before the count updates.
// item_i.ready is high only while idle, so a new request is taken only
// after the previous result is loaded into the output register.
// When result_o stalls the finished result is held in the output
// register; a new request is still taken and runs, and its result waits
// until the register frees.
// Reset clears the count and the control state; memory contents are not
// cleared, and entries beyond the count are never read.
module positional_array_list_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pal_in_if.sink     item_i,
  pal_out_if.source  result_o
);

  pal_pkg::pal_cmd_t  cmd;
  pal_pkg::pal_stat_t stat;

  // controller
  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath with element store
  pal_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mode_i        (item_i.mode),
    .in_position_i    (item_i.position),
    .in_value_i       (item_i.value),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .out_status_o     (result_o.status),
    .out_read_value_o (result_o.read_value),
    .out_count_o      (result_o.count)
  );

endmodule

`default_nettype wire
